>>> sv/gmdfs_pkg.sv
// shared constants, codes and controller/datapath interface types
// for the grid maze depth-first path finder; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package gmdfs_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_COLS  = 64;
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_W     = $clog2(MAX_COLS);
  localparam int CELL_W    = ROW_W + COL_W;
  localparam int CELLS     = MAX_ROWS * MAX_COLS;
  localparam int CNT_W     = CELL_W + 1;
  localparam int NUM_DIRS  = 4;
  localparam int DIR_W     = 3;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 3;

  localparam logic [ACT_W-1:0] ACT_LOAD   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

  localparam logic [STAT_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STAT_W-1:0] ST_FOUND   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOPATH  = 3'd2;
  localparam logic [STAT_W-1:0] ST_INVALID = 3'd3;
  localparam logic [STAT_W-1:0] ST_RANGE   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'd1;

  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;

  typedef enum logic [1:0] {
    MA_NB,
    MA_START,
    MA_GOAL
  } maze_sel_e;

  typedef struct packed {
    logic              capture;
    logic              maze_wr;
    logic              cnt_clr;
    logic              clr_init;
    logic              clr_step;
    maze_sel_e         maze_sel;
    logic              cap_sblk;
    logic              push_start;
    logic              try_step;
    logic              push_nb;
    logic              pop;
    logic              path_rd_pop;
    logic              pop_load;
    logic              out_load;
    logic [STAT_W-1:0] out_status;
    logic              out_rd;
  } dp_cmd_t;

  typedef struct packed {
    logic range_ok;
    logic clr_last;
    logic sg_blk;
    logic sg_same;
    logic dir_done;
    logic nb_inb;
    logic nb_free;
    logic nb_goal;
    logic cnt_one;
    logic idx_ok;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> sv/gmdfs_ctrl.sv
// search controller: sequences load, read and depth-first search requests
// drives datapath commands from datapath status; uses gmdfs_pkg
`timescale 1ns / 1ps
`default_nettype none

module gmdfs_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [gmdfs_pkg::ACT_W-1:0]       action_i,
  input  gmdfs_pkg::dp_stat_t               stat_i,
  output gmdfs_pkg::dp_cmd_t                cmd_o,
  output logic                              busy_o
);
  import gmdfs_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_RDS  = 4'd2;
  localparam logic [3:0] S_RDG  = 4'd3;
  localparam logic [3:0] S_EVAL = 4'd4;
  localparam logic [3:0] S_TRY  = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_POPW = 4'd7;
  localparam logic [3:0] S_RDP  = 4'd8;

  logic [3:0] state_q, state_d;
  dp_cmd_t    cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.maze_sel   = MA_NB;
    cmd.out_status = ST_DONE;
    state_d        = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd.capture = 1'b1;
          case (action_i)
            ACT_LOAD: begin
              cmd.maze_wr  = 1'b1;
              cmd.out_load = 1'b1;
            end
            ACT_SEARCH: begin
              cmd.cnt_clr  = 1'b1;
              cmd.clr_init = 1'b1;
              state_d      = S_CLR;
            end
            ACT_READ: begin
              if (stat_i.idx_ok) begin
                state_d = S_RDP;
              end else begin
                cmd.out_load   = 1'b1;
                cmd.out_status = ST_RANGE;
              end
            end
            default: begin
              cmd.out_load = 1'b1;
            end
          endcase
        end
      end
      S_CLR: begin
        if (!stat_i.range_ok) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_INVALID;
          state_d        = S_IDLE;
        end else begin
          cmd.clr_step = 1'b1;
          if (stat_i.clr_last) begin
            state_d = S_RDS;
          end
        end
      end
      S_RDS: begin
        cmd.maze_sel = MA_START;
        state_d      = S_RDG;
      end
      S_RDG: begin
        cmd.maze_sel = MA_GOAL;
        cmd.cap_sblk = 1'b1;
        state_d      = S_EVAL;
      end
      S_EVAL: begin
        if (stat_i.sg_blk) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_INVALID;
          state_d        = S_IDLE;
        end else begin
          cmd.push_start = 1'b1;
          if (stat_i.sg_same) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = ST_FOUND;
            state_d        = S_IDLE;
          end else begin
            state_d = S_TRY;
          end
        end
      end
      S_TRY: begin
        if (stat_i.dir_done) begin
          cmd.pop = 1'b1;
          if (stat_i.cnt_one) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = ST_NOPATH;
            state_d        = S_IDLE;
          end else begin
            cmd.path_rd_pop = 1'b1;
            state_d         = S_POPW;
          end
        end else begin
          cmd.try_step = 1'b1;
          if (stat_i.nb_inb) begin
            state_d = S_CHK;
          end
        end
      end
      S_CHK: begin
        state_d = S_TRY;
        if (stat_i.nb_free) begin
          cmd.push_nb = 1'b1;
          if (stat_i.nb_goal) begin
            cmd.out_load   = 1'b1;
            cmd.out_status = ST_FOUND;
            state_d        = S_IDLE;
          end
        end
      end
      S_POPW: begin
        cmd.pop_load = 1'b1;
        state_d      = S_TRY;
      end
      S_RDP: begin
        cmd.out_load = 1'b1;
        cmd.out_rd   = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign cmd_o  = cmd;
  assign busy_o = (state_q != S_IDLE);

  a_chk_after_try: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHK) |-> ($past(state_q) == S_TRY))
    else $error("neighbor check not preceded by a try");

  a_popw_after_try: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POPW) |-> ($past(state_q) == S_TRY))
    else $error("pop reload not preceded by a try");

  a_result_ends_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> !busy_o)
    else $error("result issued without returning to idle");

  a_push_only_on_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push_nb |-> (stat_i.nb_free && state_q == S_CHK))
    else $error("push of a neighbor that is not free");

endmodule

`default_nettype wire

>>> sv/gmdfs_dp.sv
// search datapath: maze, visited and path stack memories, search position,
// config registers and result register; uses gmdfs_pkg
`timescale 1ns / 1ps
`default_nettype none

module gmdfs_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gmdfs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gmdfs_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic [gmdfs_pkg::ROW_W-1:0]        cell_row_i,
  input  logic [gmdfs_pkg::COL_W-1:0]        cell_col_i,
  input  logic                               blocked_i,
  input  logic [gmdfs_pkg::ROW_W-1:0]        goal_row_i,
  input  logic [gmdfs_pkg::COL_W-1:0]        goal_col_i,
  input  logic [gmdfs_pkg::CELL_W-1:0]       path_index_i,
  input  gmdfs_pkg::dp_cmd_t                 cmd_i,
  output gmdfs_pkg::dp_stat_t                stat_o,
  output logic [gmdfs_pkg::STAT_W-1:0]       status_o,
  output logic [gmdfs_pkg::CNT_W-1:0]        path_length_o,
  output logic [gmdfs_pkg::ROW_W-1:0]        path_row_o,
  output logic [gmdfs_pkg::COL_W-1:0]        path_col_o,
  output logic                               done_o
);
  import gmdfs_pkg::*;

  // config
  logic [CFG_W-1:0] num_rows_q, num_cols_q, rows_use, cols_use;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= CFG_W'(MAX_ROWS);
      num_cols_q <= CFG_W'(MAX_COLS);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROWS: num_rows_q <= cfg_wdata_i;
        CFG_COLS: num_cols_q <= cfg_wdata_i;
        default:  ;
      endcase
    end
  end

  assign rows_use = (num_rows_q > CFG_W'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : num_rows_q;
  assign cols_use = (num_cols_q > CFG_W'(MAX_COLS)) ? CFG_W'(MAX_COLS) : num_cols_q;

  // request capture
  logic [ROW_W-1:0] sr_q, gr_q;
  logic [COL_W-1:0] sc_q, gc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sr_q <= cell_row_i;
      sc_q <= cell_col_i;
      gr_q <= goal_row_i;
      gc_q <= goal_col_i;
    end
  end

  // search position and neighbor
  logic [ROW_W-1:0]  cur_row_q, nb_row, nb_row_q;
  logic [COL_W-1:0]  cur_col_q, nb_col, nb_col_q;
  logic [DIR_W-1:0]  cur_dir_q;
  logic              nb_inb;
  logic [CELL_W-1:0] nb_k, nb_k_q, start_k, goal_k;

  always_comb begin
    nb_row = cur_row_q;
    nb_col = cur_col_q;
    nb_inb = 1'b0;
    case (cur_dir_q)
      DIR_DOWN: begin
        nb_row = cur_row_q + ROW_W'(1);
        nb_inb = (CFG_W'(cur_row_q) + CFG_W'(1)) < rows_use;
      end
      DIR_UP: begin
        nb_row = cur_row_q - ROW_W'(1);
        nb_inb = (cur_row_q != '0);
      end
      DIR_RIGHT: begin
        nb_col = cur_col_q + COL_W'(1);
        nb_inb = (CFG_W'(cur_col_q) + CFG_W'(1)) < cols_use;
      end
      DIR_LEFT: begin
        nb_col = cur_col_q - COL_W'(1);
        nb_inb = (cur_col_q != '0);
      end
      default: begin
        nb_inb = 1'b0;
      end
    endcase
  end

  assign nb_k    = {nb_row, nb_col};
  assign nb_k_q  = {nb_row_q, nb_col_q};
  assign start_k = {sr_q, sc_q};
  assign goal_k  = {gr_q, gc_q};

  // path count
  logic [CNT_W-1:0]  cnt_q, cnt_d, cnt_dec1, cnt_dec2;

  assign cnt_dec1 = cnt_q - CNT_W'(1);
  assign cnt_dec2 = cnt_q - CNT_W'(2);

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.cnt_clr) begin
      cnt_d = '0;
    end else if (cmd_i.push_start) begin
      cnt_d = CNT_W'(1);
    end else if (cmd_i.push_nb) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (cmd_i.pop) begin
      cnt_d = cnt_dec1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // clear sweep counter
  logic [CELL_W-1:0] clr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_init) begin
      clr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_q <= clr_q + CELL_W'(1);
    end
  end

  // maze memory
  logic              maze_mem [CELLS];
  logic [CELL_W-1:0] maze_raddr;
  logic              maze_rd_q, sblk_q;

  always_comb begin
    case (cmd_i.maze_sel)
      MA_START: maze_raddr = start_k;
      MA_GOAL:  maze_raddr = goal_k;
      default:  maze_raddr = nb_k;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.maze_wr) begin
      maze_mem[{cell_row_i, cell_col_i}] <= blocked_i;
    end
    maze_rd_q <= maze_mem[maze_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_sblk) begin
      sblk_q <= maze_rd_q;
    end
  end

  // visited memory
  logic              vis_mem [CELLS];
  logic              vis_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) begin
      vis_mem[clr_q] <= 1'b0;
    end else if (cmd_i.push_start) begin
      vis_mem[start_k] <= 1'b1;
    end else if (cmd_i.push_nb) begin
      vis_mem[nb_k_q] <= 1'b1;
    end
    vis_rd_q <= vis_mem[nb_k];
  end

  // path stack memories
  logic [CELL_W-1:0] path_mem [CELLS];
  logic [DIR_W-1:0]  dir_mem  [CELLS];
  logic [CELL_W-1:0] path_raddr, path_rd_q;
  logic [DIR_W-1:0]  dir_rd_q;

  assign path_raddr = cmd_i.path_rd_pop ? cnt_dec2[CELL_W-1:0] : path_index_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_start) begin
      path_mem[CELL_W'(0)] <= start_k;
    end else if (cmd_i.push_nb) begin
      path_mem[cnt_q[CELL_W-1:0]] <= nb_k_q;
    end
    if (cmd_i.push_nb) begin
      dir_mem[cnt_dec1[CELL_W-1:0]] <= cur_dir_q;
    end
    path_rd_q <= path_mem[path_raddr];
    dir_rd_q  <= dir_mem[path_raddr];
  end

  // top of stack registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_dir_q <= '0;
    end else if (cmd_i.push_start || cmd_i.push_nb) begin
      cur_dir_q <= '0;
    end else if (cmd_i.try_step) begin
      cur_dir_q <= cur_dir_q + DIR_W'(1);
    end else if (cmd_i.pop_load) begin
      cur_dir_q <= dir_rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_start) begin
      cur_row_q <= sr_q;
      cur_col_q <= sc_q;
    end else if (cmd_i.push_nb) begin
      cur_row_q <= nb_row_q;
      cur_col_q <= nb_col_q;
    end else if (cmd_i.pop_load) begin
      cur_row_q <= path_rd_q[CELL_W-1:COL_W];
      cur_col_q <= path_rd_q[COL_W-1:0];
    end
    if (cmd_i.try_step) begin
      nb_row_q <= nb_row;
      nb_col_q <= nb_col;
    end
  end

  // status to controller
  assign stat_o.range_ok = (CFG_W'(sr_q) < rows_use) && (CFG_W'(sc_q) < cols_use) &&
                           (CFG_W'(gr_q) < rows_use) && (CFG_W'(gc_q) < cols_use);
  assign stat_o.clr_last = (clr_q == CELL_W'(CELLS - 1));
  assign stat_o.sg_blk   = sblk_q | maze_rd_q;
  assign stat_o.sg_same  = (start_k == goal_k);
  assign stat_o.dir_done = (cur_dir_q >= DIR_W'(NUM_DIRS));
  assign stat_o.nb_inb   = nb_inb;
  assign stat_o.nb_free  = !maze_rd_q && !vis_rd_q && (cnt_q < CNT_W'(CELLS));
  assign stat_o.nb_goal  = (nb_k_q == goal_k);
  assign stat_o.cnt_one  = (cnt_q == CNT_W'(1));
  assign stat_o.idx_ok   = (CNT_W'(path_index_i) < cnt_q);

  // result register
  logic [STAT_W-1:0] status_q;
  logic [CNT_W-1:0]  len_q;
  logic [ROW_W-1:0]  prow_q;
  logic [COL_W-1:0]  pcol_q;
  logic              done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.out_load;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      status_q <= cmd_i.out_status;
      len_q    <= cnt_d;
      prow_q   <= cmd_i.out_rd ? path_rd_q[CELL_W-1:COL_W] : '0;
      pcol_q   <= cmd_i.out_rd ? path_rd_q[COL_W-1:0] : '0;
    end
  end

  assign status_o      = status_q;
  assign path_length_o = len_q;
  assign path_row_o    = prow_q;
  assign path_col_o    = pcol_q;
  assign done_o        = done_q;

  a_dir_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_dir_q <= DIR_W'(NUM_DIRS))
    else $error("direction counter past last neighbor");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (cnt_q != '0))
    else $error("pop from an empty path stack");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(CELLS))
    else $error("path count beyond grid storage");

endmodule

`default_nettype wire

>>> sv/grid_maze_dfs_path_finder.sv
// grid maze path finder: load/no-op requests answer from idle, reads from RDP (from idle
// if the index is out of range), searches from CLR if start or goal lies outside the grid,
// else after a visited-map sweep of MAX_ROWS*MAX_COLS cells, start/goal checks in RDS, RDG
// and EVAL, then per visited cell up to 4 neighbor tries (TRY, CHK) and a pop (TRY, POPW).
// one request at a time, the next one taken while done_o strobes its result; no stall.
// reset: grid size 64 x 64, path count 0; maze and path cells undefined until written
`timescale 1ns / 1ps
`default_nettype none

module grid_maze_dfs_path_finder (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  output logic                               done_o,
  input  logic                               cfg_we_i,
  input  logic [gmdfs_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [gmdfs_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic [gmdfs_pkg::ACT_W-1:0]        action_i,
  input  logic [gmdfs_pkg::ROW_W-1:0]        cell_row_i,
  input  logic [gmdfs_pkg::COL_W-1:0]        cell_col_i,
  input  logic                               blocked_i,
  input  logic [gmdfs_pkg::ROW_W-1:0]        goal_row_i,
  input  logic [gmdfs_pkg::COL_W-1:0]        goal_col_i,
  input  logic [gmdfs_pkg::CELL_W-1:0]       path_index_i,
  output logic [gmdfs_pkg::STAT_W-1:0]       status_o,
  output logic [gmdfs_pkg::CNT_W-1:0]        path_length_o,
  output logic [gmdfs_pkg::ROW_W-1:0]        path_row_o,
  output logic [gmdfs_pkg::COL_W-1:0]        path_col_o
);
  import gmdfs_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  gmdfs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (action_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  gmdfs_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cell_row_i    (cell_row_i),
    .cell_col_i    (cell_col_i),
    .blocked_i     (blocked_i),
    .goal_row_i    (goal_row_i),
    .goal_col_i    (goal_col_i),
    .path_index_i  (path_index_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .status_o      (status_o),
    .path_length_o (path_length_o),
    .path_row_o    (path_row_o),
    .path_col_o    (path_col_o),
    .done_o        (done_o)
  );

endmodule

`default_nettype wire

>>> sim/tb_grid_maze_dfs_path_finder.sv
// self-checking testbench for grid_maze_dfs_path_finder: a directed table, then random
// load/search/read/no-op requests over several grid sizes, checked against a local dfs predictor
// depends on gmdfs_pkg and the grid_maze_dfs_path_finder rtl
`timescale 1ns / 1ps

module tb_grid_maze_dfs_path_finder;
  import gmdfs_pkg::*;

  localparam int WATCHDOG_LIMIT = 60000;
  localparam int SETTLE_CYCLES  = 32;
  localparam int MAX_REPORTS    = 10;
  localparam logic [ACT_W-1:0] ACT_NOOP = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [ROW_W-1:0]  crow;
    logic [COL_W-1:0]  ccol;
    logic              blk;
    logic [ROW_W-1:0]  grow;
    logic [COL_W-1:0]  gcol;
    logic [CELL_W-1:0] idx;
  } maze_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  length;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } maze_res_t;

  typedef struct packed {
    logic             set_size;
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
    maze_req_t        req;
    logic             typed;
    maze_res_t        res;
  } step_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic                 done_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic [ACT_W-1:0]     action_i;
  logic [ROW_W-1:0]     cell_row_i;
  logic [COL_W-1:0]     cell_col_i;
  logic                 blocked_i;
  logic [ROW_W-1:0]     goal_row_i;
  logic [COL_W-1:0]     goal_col_i;
  logic [CELL_W-1:0]    path_index_i;
  logic [STAT_W-1:0]    status_o;
  logic [CNT_W-1:0]     path_length_o;
  logic [ROW_W-1:0]     path_row_o;
  logic [COL_W-1:0]     path_col_o;

  grid_maze_dfs_path_finder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .done_o        (done_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .action_i      (action_i),
    .cell_row_i    (cell_row_i),
    .cell_col_i    (cell_col_i),
    .blocked_i     (blocked_i),
    .goal_row_i    (goal_row_i),
    .goal_col_i    (goal_col_i),
    .path_index_i  (path_index_i),
    .status_o      (status_o),
    .path_length_o (path_length_o),
    .path_row_o    (path_row_o),
    .path_col_o    (path_col_o)
  );

  // directed requests; typed rows carry a hand-written expectation
  step_row_t directed_steps [24] = '{
    '{1'b0, 7'd0, 7'd0, '{ACT_READ, 6'd0, 6'd0, 1'b0, 6'd0, 6'd0, 12'd0},
      1'b1, '{ST_RANGE, 13'd0, 6'd0, 6'd0}},
    '{1'b0, 7'd0, 7'd0, '{ACT_NOOP, 6'd5, 6'd9, 1'b1, 6'd3, 6'd7, 12'hABC},
      1'b1, '{ST_DONE, 13'd0, 6'd0, 6'd0}},
    '{1'b0, 7'd0, 7'd0, '{ACT_LOAD, 6'd0, 6'd0, 1'b0, 6'd0, 6'd0, 12'd0},
      1'b1, '{ST_DONE, 13'd0, 6'd0, 6'd0}},
    '{1'b0, 7'd0, 7'd0, '{ACT_LOAD, 6'd63, 6'd63, 1'b1, 6'd0, 6'd0, 12'd0},
      1'b1, '{ST_DONE, 13'd0, 6'd0, 6'd0}},
    '{1'b0, 7'd0, 7'd0, '{ACT_SEARCH, 6'd0, 6'd0, 1'b0, 6'd0, 6'd0, 12'd0},
      1'b1, '{ST_FOUND, 13'd1, 6'd0, 6'd0}},
    '{1'b0, 7'd0, 7'd0, '{ACT_READ, 6'd0, 6'd0, 1'b0, 6'd0, 6'd0, 12'd0},
      1'b1, '{ST_DONE, 13'd1, 6'd0, 6'd0}},
    '{1'b0, 7'd0, 7'd0, '{ACT_READ, 6'd0, 6'd0, 1'b0, 6'd0, 6'd0, 12'd4095},
      1'b1, '{ST_RANGE, 13'd1, 6'd0, 6'd0}},
    '{1'b0, 7'd0, 7'd0, '{ACT_SEARCH, 6'd0, 6'd0, 1'b0, 6'd63, 6'd63, 12'd0},
      1'b1, '{ST_INVALID, 13'd0, 6'd0, 6'd0}},
    '{1'b0, 7'd0, 7'd0, '{ACT_LOAD, 6'd63, 6'd63, 1'b0, 6'd0, 6'd0, 12'd0},
      1'b1, '{ST_DONE, 13'd0, 6'd0, 6'd0}},
    '{1'b0, 7'd0, 7'd0, '{ACT_SEARCH, 6'd63, 6'd63, 1'b0, 6'd63, 6'd63, 12'd0},
      1'b1, '{ST_FOUND, 13'd1, 6'd0, 6'd0}},
    '{1'b0, 7'd0, 7'd0, '{ACT_READ, 6'd0, 6'd0, 1'b0, 6'd0, 6'd0, 12'd0},
      1'b1, '{ST_DONE, 13'd1, 6'd63, 6'd63}},
    // empty grid: every search is invalid
    '{1'b1, 7'd0, 7'd127, '{ACT_SEARCH, 6'd0, 6'd0, 1'b0, 6'd0, 6'd0, 12'd0},
      1'b1, '{ST_INVALID, 13'd0, 6'd0, 6'd0}},
    '{1'b1, 7'd2, 7'd3, '{ACT_LOAD, 6'd0, 6'd0, 1'b0, 6'd0, 6'd0, 12'd0},
      1'b1, '{ST_DONE, 13'd0, 6'd0, 6'd0}},
    '{1'b0, 7'd0, 7'd0, '{ACT_LOAD, 6'd0, 6'd1, 1'b0, 6'd0, 6'd0, 12'd0},
      1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{ACT_LOAD, 6'd0, 6'd2, 1'b1, 6'd0, 6'd0, 12'd0},
      1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{ACT_LOAD, 6'd1, 6'd0, 1'b0, 6'd0, 6'd0, 12'd0},
      1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{ACT_LOAD, 6'd1, 6'd1, 1'b0, 6'd0, 6'd0, 12'd0},
      1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{ACT_LOAD, 6'd1, 6'd2, 1'b0, 6'd0, 6'd0, 12'd0},
      1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{ACT_SEARCH, 6'd0, 6'd0, 1'b0, 6'd1, 6'd2, 12'd0},
      1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{ACT_READ, 6'd0, 6'd0, 1'b0, 6'd0, 6'd0, 12'd3},
      1'b0, '0},
    // goal outside the grid in use
    '{1'b0, 7'd0, 7'd0, '{ACT_SEARCH, 6'd0, 6'd0, 1'b0, 6'd0, 6'd5, 12'd0},
      1'b1, '{ST_INVALID, 13'd0, 6'd0, 6'd0}},
    '{1'b0, 7'd0, 7'd0, '{ACT_LOAD, 6'd1, 6'd1, 1'b1, 6'd0, 6'd0, 12'd0},
      1'b1, '{ST_DONE, 13'd0, 6'd0, 6'd0}},
    '{1'b0, 7'd0, 7'd0, '{ACT_SEARCH, 6'd0, 6'd0, 1'b0, 6'd1, 6'd2, 12'd0},
      1'b0, '0},
    '{1'b0, 7'd0, 7'd0, '{ACT_READ, 6'd0, 6'd0, 1'b0, 6'd0, 6'd0, 12'd0},
      1'b1, '{ST_RANGE, 13'd0, 6'd0, 6'd0}}
  };

  // predictor state
  bit        cell_wall  [CELLS];
  bit        cell_known [CELLS];
  bit        cell_seen  [CELLS];
  int        trail_row  [CELLS];
  int        trail_col  [CELLS];
  int        trail_try  [CELLS];
  int        trail_len;
  int        size_rows;
  int        size_cols;
  int        known_cells [$];
  maze_res_t expected_q [$];

  int idle_pct;
  int fault_cnt;
  int stall_cycles;
  int load_cnt;
  int read_cnt;
  int search_tally [5];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int cell_at(int r, int c);
    return r * MAX_COLS + c;
  endfunction

  function automatic void push_trail(int r, int c);
    cell_seen[cell_at(r, c)] = 1'b1;
    trail_row[trail_len] = r;
    trail_col[trail_len] = c;
    trail_try[trail_len] = 0;
    trail_len++;
  endfunction

  function automatic logic [STAT_W-1:0] walk_maze(int sr, int sc, int gr, int gc);
    int rows;
    int cols;
    int top;
    int d;
    int nr;
    int nc;
    rows = (size_rows > MAX_ROWS) ? MAX_ROWS : size_rows;
    cols = (size_cols > MAX_COLS) ? MAX_COLS : size_cols;
    trail_len = 0;
    foreach (cell_seen[k]) cell_seen[k] = 1'b0;
    if (sr >= rows || sc >= cols || gr >= rows || gc >= cols) return ST_INVALID;
    if (cell_wall[cell_at(sr, sc)] || cell_wall[cell_at(gr, gc)]) return ST_INVALID;
    push_trail(sr, sc);
    if (sr == gr && sc == gc) return ST_FOUND;
    while (trail_len > 0) begin
      top = trail_len - 1;
      d = trail_try[top];
      if (d >= NUM_DIRS) begin
        trail_len--;
        continue;
      end
      trail_try[top] = d + 1;
      nr = trail_row[top] + ((d == DIR_DOWN) ? 1 : (d == DIR_UP) ? -1 : 0);
      nc = trail_col[top] + ((d == DIR_RIGHT) ? 1 : (d == DIR_LEFT) ? -1 : 0);
      if (nr >= 0 && nr < rows && nc >= 0 && nc < cols && trail_len < CELLS) begin
        if (!cell_wall[cell_at(nr, nc)] && !cell_seen[cell_at(nr, nc)]) begin
          push_trail(nr, nc);
          if (nr == gr && nc == gc) return ST_FOUND;
        end
      end
    end
    return ST_NOPATH;
  endfunction

  function automatic maze_res_t predict_result(maze_req_t r);
    maze_res_t res;
    int k;
    res = '0;
    case (r.action)
      ACT_LOAD: begin
        k = cell_at(r.crow, r.ccol);
        cell_wall[k] = r.blk;
        if (!cell_known[k]) begin
          cell_known[k] = 1'b1;
          known_cells.push_back(k);
        end
      end
      ACT_SEARCH: res.status = walk_maze(r.crow, r.ccol, r.grow, r.gcol);
      ACT_READ: begin
        if (r.idx < trail_len) begin
          res.row = ROW_W'(trail_row[r.idx]);
          res.col = COL_W'(trail_col[r.idx]);
        end else begin
          res.status = ST_RANGE;
        end
      end
      default: res.status = ST_DONE;
    endcase
    res.length = CNT_W'(trail_len);
    return res;
  endfunction

  task automatic send_request(maze_req_t r, logic typed, maze_res_t typed_res);
    maze_res_t res;
    int gap;
    action_i     <= r.action;
    cell_row_i   <= r.crow;
    cell_col_i   <= r.ccol;
    blocked_i    <= r.blk;
    goal_row_i   <= r.grow;
    goal_col_i   <= r.gcol;
    path_index_i <= r.idx;
    start        <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
    res = predict_result(r);
    case (r.action)
      ACT_LOAD:   load_cnt++;
      ACT_READ:   read_cnt++;
      ACT_SEARCH: search_tally[res.status]++;
      default: ;
    endcase
    expected_q.push_back(typed ? typed_res : res);
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  task automatic set_grid(int rows, int cols);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ROWS;
    cfg_wdata_i <= CFG_W'(rows);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_COLS;
    cfg_wdata_i <= CFG_W'(cols);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    size_rows = rows;
    size_cols = cols;
    @(posedge clk_i);
  endtask

  // fill loads every cell in use first, so any search may walk the whole grid;
  // without fill only searches that touch nothing but loaded start/goal cells are made
  task automatic run_phase(int rows, int cols, bit fill, int count);
    maze_req_t q;
    logic [63:0] noise;
    int er;
    int ec;
    int pick;
    int s;
    int g;
    er = (rows > MAX_ROWS) ? MAX_ROWS : rows;
    ec = (cols > MAX_COLS) ? MAX_COLS : cols;
    set_grid(rows, cols);
    if (fill) begin
      for (int r = 0; r < er; r++) begin
        for (int c = 0; c < ec; c++) begin
          noise = {$urandom, $urandom};
          q = noise[$bits(maze_req_t)-1:0];
          q.action = ACT_LOAD;
          q.crow = ROW_W'(r);
          q.ccol = COL_W'(c);
          q.blk = ($urandom_range(99) < 28);
          send_request(q, 1'b0, '0);
        end
      end
    end
    repeat (count) begin
      if ($urandom_range(99) < 4) drain_results();
      noise = {$urandom, $urandom};
      q = noise[$bits(maze_req_t)-1:0];
      pick = $urandom_range(99);
      if (pick < 20) begin
        q.action = ACT_LOAD;
        if (fill && $urandom_range(3) != 0) begin
          q.crow = ROW_W'($urandom_range(er - 1));
          q.ccol = COL_W'($urandom_range(ec - 1));
          q.blk = ($urandom_range(99) < 30);
        end
      end else if (pick < 55) begin
        q.action = ACT_SEARCH;
        if (fill) begin
          if ($urandom_range(9) != 0) begin
            q.crow = ROW_W'($urandom_range(er - 1));
            q.ccol = COL_W'($urandom_range(ec - 1));
            q.grow = ROW_W'($urandom_range(er - 1));
            q.gcol = COL_W'($urandom_range(ec - 1));
          end
          if ($urandom_range(9) == 0) begin
            q.grow = q.crow;
            q.gcol = q.ccol;
          end
        end else if (er > 0 && ec > 0) begin
          s = known_cells[$urandom_range(known_cells.size() - 1)];
          g = known_cells[$urandom_range(known_cells.size() - 1)];
          if (!cell_wall[s] && !cell_wall[g]) g = s;
          q.crow = ROW_W'(s / MAX_COLS);
          q.ccol = COL_W'(s % MAX_COLS);
          q.grow = ROW_W'(g / MAX_COLS);
          q.gcol = COL_W'(g % MAX_COLS);
        end
      end else if (pick < 90) begin
        q.action = ACT_READ;
        if ($urandom_range(3) != 0) q.idx = CELL_W'($urandom_range(trail_len + 1));
      end else begin
        q.action = ACT_NOOP;
      end
      send_request(q, 1'b0, '0);
    end
  endtask

  always @(posedge clk_i) begin
    maze_res_t got;
    maze_res_t want;
    if (rst_ni && done_o) begin
      got = '{status_o, path_length_o, path_row_o, path_col_o};
      if (expected_q.size() == 0) begin
        if (fault_cnt < MAX_REPORTS)
          $display("unexpected result: status %0d length %0d row %0d col %0d",
                   got.status, got.length, got.row, got.col);
        fault_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          if (fault_cnt < MAX_REPORTS)
            $display("mismatch: status %0d/%0d length %0d/%0d row %0d/%0d col %0d/%0d %s",
                     got.status, want.status, got.length, want.length,
                     got.row, want.row, got.col, want.col, "(got/expected)");
          fault_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no request or result for %0d cycles", stall_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    start        <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_idx_i    <= CFG_ROWS;
    cfg_wdata_i  <= '0;
    action_i     <= ACT_LOAD;
    cell_row_i   <= '0;
    cell_col_i   <= '0;
    blocked_i    <= 1'b0;
    goal_row_i   <= '0;
    goal_col_i   <= '0;
    path_index_i <= '0;
    size_rows = MAX_ROWS;
    size_cols = MAX_COLS;
    trail_len = 0;
    fault_cnt = 0;
    load_cnt = 0;
    read_cnt = 0;
    foreach (search_tally[i]) search_tally[i] = 0;
    idle_pct = 6;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].set_size)
        set_grid(directed_steps[i].rows, directed_steps[i].cols);
      send_request(directed_steps[i].req, directed_steps[i].typed, directed_steps[i].res);
    end

    run_phase(6, 6, 1'b1, 45);
    run_phase(1, 64, 1'b1, 45);
    idle_pct = 59;
    run_phase(127, 1, 1'b1, 45);
    run_phase(0, 5, 1'b0, 20);
    idle_pct = 0;
    run_phase(64, 127, 1'b0, 45);
    run_phase(7, 5, 1'b1, 45);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("covered %0d loads, %0d reads and %0d found / %0d no-path / %0d invalid searches",
             load_cnt, read_cnt, search_tally[ST_FOUND], search_tally[ST_NOPATH],
             search_tally[ST_INVALID]);
    $display("grid sizes from empty to oversized registers, %0d mismatches", fault_cnt);
    if (fault_cnt == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> grid_maze_dfs_path_finder.f
sv/gmdfs_pkg.sv
sv/gmdfs_ctrl.sv
sv/gmdfs_dp.sv
sv/grid_maze_dfs_path_finder.sv
sim/tb_grid_maze_dfs_path_finder.sv
